[hdl/glyph_row_renderer_top_macros.svh]
// Assertion macros for the glyph row renderer.
`ifndef GLYPH_ROW_RENDERER_TOP_MACROS_SVH
`define GLYPH_ROW_RENDERER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GRR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GRR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles.
`define GRR_ASSERT_AFTER(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`endif

[hdl/grr_pkg.sv]
package grr_pkg;

   localparam int GLYPH_ROWS = 16;
   localparam int GLYPH_COLS = 8;

   localparam logic [3:0] GLYPH_LAST_ROW = 4'd15;
   localparam logic [6:0] SPACE_CODE     = 7'd32;

   // cycles from the accepting edge to the edge that takes the first row
   localparam int RSP_LATENCY = 3;

   // configuration register indexes
   localparam logic [3:0] CSR_FB_ENABLE     = 4'd0;
   localparam logic [3:0] CSR_SCREEN_WIDTH  = 4'd1;
   localparam logic [3:0] CSR_SCREEN_HEIGHT = 4'd2;
   localparam logic [3:0] CSR_ROW_PITCH     = 4'd3;

   localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd768;
   // pitch 4096 bytes is a stride of 1024 words
   localparam logic [12:0] ROW_STRIDE_RESET    = 13'd1024;

   typedef logic [0:15][7:0] glyph_type;

   typedef struct packed {
      logic              fb_enable;
      logic [12:0]       screen_width;
      logic [12:0]       screen_height;
      logic [12:0]       row_stride;
   } grr_cfg_type;

   typedef struct packed {
      logic               valid;
      logic [3:0]         row;
      logic signed [16:0] py;
      logic signed [15:0] x;
      logic [31:0]        color;
   } grr_issue_type;

   function automatic glyph_type glyph_lookup(input logic [6:0] code);
      glyph_type g;
      g = '0;
      unique case (code)
         7'd33:  g = '{8'h00,8'h18,8'h18,8'h18,8'h18,8'h18,8'h00,8'h18,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd62:  g = '{8'h00,8'h60,8'h30,8'h18,8'h0C,8'h18,8'h30,8'h60,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd65:  g = '{8'h00,8'h18,8'h3C,8'h66,8'h66,8'h66,8'h7E,8'h66,
                       8'h66,8'h66,8'h66,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd66:  g = '{8'h00,8'h7C,8'h66,8'h66,8'h7C,8'h66,8'h66,8'h66,
                       8'h7C,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd67:  g = '{8'h00,8'h3C,8'h66,8'h60,8'h60,8'h60,8'h66,8'h3C,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd68:  g = '{8'h00,8'h78,8'h6C,8'h66,8'h66,8'h66,8'h6C,8'h78,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd69:  g = '{8'h00,8'h7E,8'h60,8'h60,8'h7C,8'h60,8'h60,8'h7E,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd70:  g = '{8'h00,8'h7E,8'h60,8'h60,8'h7C,8'h60,8'h60,8'h60,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd71:  g = '{8'h00,8'h3C,8'h66,8'h60,8'h6E,8'h66,8'h66,8'h3E,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd72:  g = '{8'h00,8'h66,8'h66,8'h66,8'h7E,8'h66,8'h66,8'h66,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd73:  g = '{8'h00,8'h3C,8'h18,8'h18,8'h18,8'h18,8'h18,8'h3C,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd76:  g = '{8'h00,8'h60,8'h60,8'h60,8'h60,8'h60,8'h60,8'h7E,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd78:  g = '{8'h00,8'h3C,8'h66,8'h66,8'h66,8'h66,8'h66,8'h3C,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd79:  g = '{8'h00,8'h7C,8'h66,8'h66,8'h7C,8'h60,8'h60,8'h60,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd82:  g = '{8'h00,8'h7C,8'h66,8'h66,8'h7C,8'h6C,8'h66,8'h63,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd83:  g = '{8'h00,8'h3C,8'h66,8'h30,8'h1C,8'h06,8'h66,8'h3C,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd84:  g = '{8'h00,8'h7E,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd97:  g = '{8'h00,8'h00,8'h00,8'h3C,8'h06,8'h3E,8'h66,8'h3E,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd100: g = '{8'h00,8'h06,8'h06,8'h3E,8'h66,8'h66,8'h66,8'h3E,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd101: g = '{8'h00,8'h00,8'h00,8'h3C,8'h66,8'h7E,8'h60,8'h3C,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd104: g = '{8'h00,8'h60,8'h60,8'h7C,8'h66,8'h66,8'h66,8'h66,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd105: g = '{8'h00,8'h18,8'h00,8'h38,8'h18,8'h18,8'h18,8'h3C,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd111: g = '{8'h00,8'h00,8'h00,8'h3C,8'h66,8'h66,8'h66,8'h3C,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd115: g = '{8'h00,8'h00,8'h00,8'h3E,8'h60,8'h3C,8'h06,8'h7C,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         7'd116: g = '{8'h00,8'h18,8'h18,8'h7E,8'h18,8'h18,8'h18,8'h0E,
                       8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

[hdl/glyph_row_renderer_top.sv]
// Glyph row renderer: draws one 8x16 character into a 32-bit framebuffer as
// sixteen row writes.
// Input channel: drive start with req_char_code, req_pos_x, req_pos_y and
// req_ink_color; the item is taken at a rising edge with start high and busy low.
// Result channel: each row item sits on the rsp_ ports for one cycle, marked
// by rsp_valid. It carries the word index of the row's left column, an 8-bit
// write mask (bit 7 is the left column), the color, the glyph row and a flag
// on the last row. The receiver cannot stall; rows simply stream out.
// Pipeline: each row goes from the row counter through the stage-1 register and
// the result registers; the sixteen rows follow on consecutive cycles, top row first.
// Throughput: one row per cycle, issued by the row counter. busy stays high
// after an accept and drops while the last row issues, so a new character can
// follow with no gap in the rows.
// Configuration: csr_index / csr_wdata, written when csr_valid and csr_ready
// are high; csr_ready is always high. Write only while no character is in
// flight. Unknown indexes are ignored.
// Reset (synchronous, active high): drop any character in flight, disable the
// framebuffer, restore 1024x768 with a 4096-byte pitch.
module glyph_row_renderer_top (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_char_code,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [31:0]        req_ink_color,
   // result channel
   output logic               rsp_valid,
   output logic [31:0]        rsp_word_index,
   output logic [7:0]         rsp_write_mask,
   output logic [31:0]        rsp_pixel_value,
   output logic [3:0]         rsp_glyph_row,
   output logic               rsp_last_row,
   // configuration port
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import grr_pkg::*;

`include "glyph_row_renderer_top_macros.svh"

   logic          fb_enable_ff;
   logic [12:0]   screen_width_ff;
   logic [12:0]   screen_height_ff;
   logic [12:0]   row_stride_ff;
   logic          csr_write;
   grr_cfg_type   cfg;
   grr_issue_type issue;
   logic [6:0]    rom_code;
   logic [3:0]    rom_row;
   logic [7:0]    rom_data;

   // registers are always ready to take a write
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // keep the pitch only as a word stride: drop the two byte bits
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_enable_ff     <= 1'b0;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         row_stride_ff    <= ROW_STRIDE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FB_ENABLE:     fb_enable_ff     <= csr_wdata[0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata[12:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata[12:0];
            CSR_ROW_PITCH:     row_stride_ff    <= csr_wdata[14:2];
            default: ;
         endcase
      end
   end

   assign cfg.fb_enable     = fb_enable_ff;
   assign cfg.screen_width  = screen_width_ff;
   assign cfg.screen_height = screen_height_ff;
   assign cfg.row_stride    = row_stride_ff;

   // row counter: holds the current character and issues one row per cycle
   grr_row_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .char_code (req_char_code),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .ink_color (req_ink_color),
      .busy      (busy),
      .rom_code  (rom_code),
      .rom_row   (rom_row),
      .issue     (issue)
   );

   // font ROM, read in parallel with the row's first pipeline stage
   grr_font_rom u_rom (
      .clock   (clock),
      .rd_code (rom_code),
      .rd_row  (rom_row),
      .rd_data (rom_data)
   );

   // address multiply, clipping and the result registers
   grr_row_calc u_calc (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .issue           (issue),
      .rom_data        (rom_data),
      .rsp_valid       (rsp_valid),
      .rsp_word_index  (rsp_word_index),
      .rsp_write_mask  (rsp_write_mask),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_glyph_row   (rsp_glyph_row),
      .rsp_last_row    (rsp_last_row)
   );

   // an accepted character shows its top row after the pipeline latency
   `GRR_ASSERT_AFTER(a_first_row, start && !busy, RSP_LATENCY, rsp_valid && (rsp_glyph_row == 4'd0), "first row missing after accept")
   // rows of one character stream without gaps
   `GRR_ASSERT_NEXT(a_row_step, rsp_valid && !rsp_last_row, rsp_valid && (rsp_glyph_row == 4'($past(rsp_glyph_row) + 4'd1)), "row sequence broken")
   // after the last row only a fresh character may follow
   `GRR_ASSERT_NEXT(a_after_last, rsp_valid && rsp_last_row, !rsp_valid || (rsp_glyph_row == 4'd0), "row after last row is not a top row")
   // the last-row flag marks row fifteen only
   `GRR_ASSERT_NOW(a_last_flag, rsp_valid, rsp_last_row == (rsp_glyph_row == GLYPH_LAST_ROW), "last row flag mismatch")

endmodule

[hdl/grr_font_rom.sv]
module grr_font_rom (
   input  logic       clock,
   input  logic [6:0] rd_code,
   input  logic [3:0] rd_row,
   output logic [7:0] rd_data
);
   import grr_pkg::*;

   logic [7:0] rd_data_ff;
   glyph_type  glyph;

   assign glyph = glyph_lookup(rd_code);

   // synchronous read into an output register
   always_ff @(posedge clock) begin
      rd_data_ff <= glyph[rd_row];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/grr_row_seq.sv]
module grr_row_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [7:0]             char_code,
   input  logic signed [15:0]     pos_x,
   input  logic signed [15:0]     pos_y,
   input  logic [31:0]            ink_color,
   output logic                   busy,
   output logic [6:0]             rom_code,
   output logic [3:0]             rom_row,
   output grr_pkg::grr_issue_type issue
);
   import grr_pkg::*;

   logic               active_ff, active_in;
   logic [3:0]         row_ff, row_in;
   logic [6:0]         code_ff;
   logic signed [15:0] x_ff;
   logic signed [15:0] y_ff;
   logic [31:0]        color_ff;
   logic               accept;

   // free again on the cycle that issues the last row
   assign busy   = active_ff && (row_ff != GLYPH_LAST_ROW);
   assign accept = start && !busy;

   always_comb begin
      active_in = active_ff;
      row_in    = row_ff;
      priority if (accept) begin
         active_in = 1'b1;
         row_in    = '0;
      end else if (active_ff) begin
         active_in = (row_ff != GLYPH_LAST_ROW);
         row_in    = row_ff + 4'd1;
      end else begin
         // hold while idle
         active_in = active_ff;
         row_in    = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         row_ff    <= '0;
      end else begin
         active_ff <= active_in;
         row_ff    <= row_in;
      end
   end

   // codes of 128 and up draw as a space
   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff  <= char_code[7] ? SPACE_CODE : char_code[6:0];
         x_ff     <= pos_x;
         y_ff     <= pos_y;
         color_ff <= ink_color;
      end
   end

   assign rom_code = code_ff;
   assign rom_row  = row_ff;

   assign issue.valid = active_ff;
   assign issue.row   = row_ff;
   assign issue.py    = {y_ff[15], y_ff} + $signed({13'd0, row_ff});
   assign issue.x     = x_ff;
   assign issue.color = color_ff;

endmodule

[hdl/grr_row_calc.sv]
module grr_row_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  grr_pkg::grr_cfg_type   cfg,
   input  grr_pkg::grr_issue_type issue,
   input  logic [7:0]             rom_data,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_word_index,
   output logic [7:0]             rsp_write_mask,
   output logic [31:0]            rsp_pixel_value,
   output logic [3:0]             rsp_glyph_row,
   output logic                   rsp_last_row
);
   import grr_pkg::*;

   grr_issue_type      s1_ff;
   logic signed [30:0] product;
   logic [31:0]        word_index;
   logic signed [16:0] screen_w;
   logic signed [16:0] screen_h;
   logic               row_ok;
   logic [7:0]         clip;
   logic signed [16:0] px [GLYPH_COLS];

   logic               rsp_valid_ff;
   logic [31:0]        rsp_word_index_ff;
   logic [7:0]         rsp_write_mask_ff;
   logic [31:0]        rsp_pixel_value_ff;
   logic [3:0]         rsp_glyph_row_ff;
   logic               rsp_last_row_ff;

   // align the row with the font data read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= issue.valid;
      end
      s1_ff.row   <= issue.row;
      s1_ff.py    <= issue.py;
      s1_ff.x     <= issue.x;
      s1_ff.color <= issue.color;
   end

   assign screen_w = $signed({4'd0, cfg.screen_width});
   assign screen_h = $signed({4'd0, cfg.screen_height});

   assign product    = $signed({{14{s1_ff.py[16]}}, s1_ff.py})
                     * $signed({18'd0, cfg.row_stride});
   assign word_index = {product[30], product} + {{16{s1_ff.x[15]}}, s1_ff.x};

   assign row_ok = cfg.fb_enable && !s1_ff.py[16] && (s1_ff.py < screen_h);

   always_comb begin
      for (int k = 0; k < GLYPH_COLS; k++) begin
         px[k]        = {s1_ff.x[15], s1_ff.x} + $signed(17'(k));
         clip[7 - k]  = row_ok && !px[k][16] && (px[k] < screen_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_ff.valid;
      end
      rsp_word_index_ff  <= word_index;
      rsp_write_mask_ff  <= rom_data & clip;
      rsp_pixel_value_ff <= s1_ff.color;
      rsp_glyph_row_ff   <= s1_ff.row;
      rsp_last_row_ff    <= (s1_ff.row == GLYPH_LAST_ROW);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_index  = rsp_word_index_ff;
   assign rsp_write_mask  = rsp_write_mask_ff;
   assign rsp_pixel_value = rsp_pixel_value_ff;
   assign rsp_glyph_row   = rsp_glyph_row_ff;
   assign rsp_last_row    = rsp_last_row_ff;

endmodule
